// File: src/delimited_frame_id_decoder_defines.svh
// assertion macros for the delimited frame id decoder
// no dependencies; included by the modules that carry assertions
`ifndef DELIMITED_FRAME_ID_DECODER_DEFINES_SVH
`define DELIMITED_FRAME_ID_DECODER_DEFINES_SVH
`ifndef SYNTH
// check on every clock edge outside reset
`define DFID_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("dfid assertion failed");
// check on every clock edge, reset included
`define DFID_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("dfid assertion failed");
`else
`define DFID_ASSERT(lbl, prop)
`define DFID_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: src/dfid_pkg.sv
// shared types, constants and the id table of the delimited frame id decoder
// no dependencies
package dfid_pkg;

	// frame size limit and the payload length cap derived from it
	localparam int MAX_FRAME = 2048;
	localparam int LEN_W = 11;
	localparam int LIMIT_INT = (MAX_FRAME - 2 > 2046) ? 2046 : MAX_FRAME - 2;
	localparam logic [LEN_W-1:0] FRAME_LIMIT = LEN_W'(LIMIT_INT);

	// delimiter bytes: header is lf cr, tail is cr lf
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_SEEN  = 2'd1,
		PH_FRAME = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SHORT      = 2'd1,
		ST_UNKNOWN_ID = 2'd2,
		ST_OVERFLOW   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        payload_byte;
		logic [LEN_W-1:0]  frame_length;
		logic [7:0]        msg_type;
		logic [3:0]        mapped_id;
		status_t           frame_status;
	} result_t;

	// raw id byte to id 1..13, 0 when unknown
	function automatic logic [3:0] map_id(input logic [7:0] raw);
		logic [3:0] id;
		unique case (raw)
			8'd97:   id = 4'd1;
			8'd98:   id = 4'd2;
			8'd99:   id = 4'd3;
			8'd112:  id = 4'd4;
			8'd120:  id = 4'd5;
			8'd102:  id = 4'd6;
			8'd111:  id = 4'd7;
			8'd121:  id = 4'd8;
			8'd103:  id = 4'd9;
			8'd108:  id = 4'd10;
			8'd107:  id = 4'd11;
			8'd106:  id = 4'd12;
			8'd238:  id = 4'd13;
			default: id = 4'd0;
		endcase
		return id;
	endfunction

endpackage

// File: src/dfid_front.sv
// front part: header hunt, one-byte hold-back, tail and limit detection
// depends on dfid_pkg and the assertion macro header
`include "delimited_frame_id_decoder_defines.svh"

module dfid_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	output logic             push,
	output dfid_pkg::result_t result
);

	dfid_pkg::phase_t phase_q, phase_d;
	logic                       held_valid_q, held_valid_d;
	logic [7:0]                 held_byte_q, held_byte_d;
	logic [dfid_pkg::LEN_W-1:0] count_q, count_d;
	logic [7:0]                 type_q, type_d;
	logic [7:0]                 raw_id_q, raw_id_d;

	logic       is_tail;
	logic       at_limit;
	logic [3:0] id_lookup;

	assign is_tail   = held_valid_q && (held_byte_q == dfid_pkg::BYTE_CR)
		&& (rx_byte == dfid_pkg::BYTE_LF);
	assign at_limit  = held_valid_q && (count_q >= dfid_pkg::FRAME_LIMIT);
	assign id_lookup = dfid_pkg::map_id(raw_id_q);

	// next phase
	always_comb begin
		unique case (phase_q)
			dfid_pkg::PH_SEEN: begin
				if (rx_byte == dfid_pkg::BYTE_CR) begin
					phase_d = dfid_pkg::PH_FRAME;
				end else if (rx_byte == dfid_pkg::BYTE_LF) begin
					phase_d = dfid_pkg::PH_SEEN;
				end else begin
					phase_d = dfid_pkg::PH_HUNT;
				end
			end
			dfid_pkg::PH_FRAME: begin
				if (is_tail) begin
					phase_d = dfid_pkg::PH_HUNT;
				end else if (at_limit) begin
					phase_d = (rx_byte == dfid_pkg::BYTE_LF) ? dfid_pkg::PH_SEEN
						: dfid_pkg::PH_HUNT;
				end else begin
					phase_d = dfid_pkg::PH_FRAME;
				end
			end
			default: begin
				phase_d = (rx_byte == dfid_pkg::BYTE_LF) ? dfid_pkg::PH_SEEN
					: dfid_pkg::PH_HUNT;
			end
		endcase
	end

	// result item and frame register updates
	always_comb begin
		push         = 1'b0;
		result       = '0;
		held_valid_d = held_valid_q;
		held_byte_d  = held_byte_q;
		count_d      = count_q;
		type_d       = type_q;
		raw_id_d     = raw_id_q;
		unique case (phase_q)
			dfid_pkg::PH_SEEN: begin
				if (rx_byte == dfid_pkg::BYTE_CR) begin
					held_valid_d = 1'b0;
					held_byte_d  = '0;
					count_d      = '0;
					type_d       = '0;
					raw_id_d     = '0;
				end
			end
			dfid_pkg::PH_FRAME: begin
				if (!held_valid_q) begin
					held_valid_d = 1'b1;
					held_byte_d  = rx_byte;
				end else if (is_tail || at_limit) begin
					// frame summary, tail or overflow abort
					push                = accept;
					result.kind         = dfid_pkg::KIND_SUMMARY;
					result.frame_length = count_q;
					result.msg_type     = (count_q != '0) ? type_q : 8'd0;
					if (!is_tail) begin
						result.frame_status = dfid_pkg::ST_OVERFLOW;
					end else if (count_q < dfid_pkg::LEN_W'(2)) begin
						result.frame_status = dfid_pkg::ST_SHORT;
					end else if (id_lookup != 4'd0) begin
						result.frame_status = dfid_pkg::ST_OK;
						result.mapped_id    = id_lookup;
					end else begin
						result.frame_status = dfid_pkg::ST_UNKNOWN_ID;
					end
					held_valid_d = 1'b0;
					held_byte_d  = '0;
				end else begin
					// release the held byte one step late
					push                = accept;
					result.kind         = dfid_pkg::KIND_PAYLOAD;
					result.payload_byte = held_byte_q;
					if (count_q == '0) begin
						type_d = held_byte_q;
					end
					if (count_q == dfid_pkg::LEN_W'(1)) begin
						raw_id_d = held_byte_q;
					end
					count_d     = count_q + dfid_pkg::LEN_W'(1);
					held_byte_d = rx_byte;
				end
			end
			default: begin
			end
		endcase
	end

	// state registers, updated per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= dfid_pkg::PH_HUNT;
			held_valid_q <= 1'b0;
			held_byte_q  <= '0;
			count_q      <= '0;
			type_q       <= '0;
			raw_id_q     <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			held_valid_q <= held_valid_d;
			held_byte_q  <= held_byte_d;
			count_q      <= count_d;
			type_q       <= type_d;
			raw_id_q     <= raw_id_d;
		end
	end

	// byte count stays within the limit
	`DFID_ASSERT(a_count_in_range, count_q <= dfid_pkg::FRAME_LIMIT)
	// an ok summary always carries a mapped id, other summaries never do
	`DFID_ASSERT(a_id_matches_status, push && result.kind == dfid_pkg::KIND_SUMMARY |-> ((result.frame_status == dfid_pkg::ST_OK) == (result.mapped_id != 4'd0)))
	// an overflow summary reports the limit as length
	`DFID_ASSERT(a_overflow_length, push && result.frame_status == dfid_pkg::ST_OVERFLOW && result.kind == dfid_pkg::KIND_SUMMARY |-> result.frame_length == dfid_pkg::FRAME_LIMIT)
	// a summary always ends the frame
	`DFID_ASSERT(a_summary_rehunts, push && result.kind == dfid_pkg::KIND_SUMMARY |=> phase_q != dfid_pkg::PH_FRAME && !held_valid_q)

endmodule

// File: src/dfid_back.sv
// back part: two-entry result queue whose head drives the output stream
// depends on dfid_pkg and the assertion macro header
`include "delimited_frame_id_decoder_defines.svh"

module dfid_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dfid_pkg::result_t push_data,
	output logic              space,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata,
	output logic              m_axis_tlast
);

	dfid_pkg::result_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;
	dfid_pkg::result_t head;

	assign space         = (count_q != 2'd2);
	assign m_axis_tvalid = (count_q != 2'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign head          = slot_q[rd_ptr_q];

	// output packing, lowest field first
	assign m_axis_tlast = head.kind;
	assign m_axis_tdata = {7'd0, head.frame_status, head.mapped_id, head.msg_type,
		head.frame_length, head.payload_byte};

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue never holds more than two entries
	`DFID_ASSERT(a_count_max, count_q <= 2'd2)
	// no push into a full queue
	`DFID_ASSERT(a_no_overrun, push |-> space)
	// pointer distance agrees with the fill level
	`DFID_ASSERT(a_ptr_level, (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
	// push without pop grows the level by one
	`DFID_ASSERT(a_level_grows, push && !pop |=> count_q == $past(count_q) + 2'd1)

endmodule

// File: src/delimited_frame_id_decoder.sv
// Delimited frame id decoder: takes one received byte per transaction and
// hunts for the header 0x0A 0x0D, then passes payload bytes on one
// transaction late (so the 0x0D of the tail 0x0D 0x0A is never passed on)
// and closes each frame with a summary item carrying length, type byte,
// status and the id mapped to 1..13. Frames longer than the length limit are
// aborted with an overflow summary. A byte is taken in every cycle while the
// two-entry result queue has room; each byte gives at most one result item,
// so with a ready sink the block sustains one byte per clock and the queue
// only fills when the output side stalls. tlast marks a summary item.
// depends on dfid_pkg, dfid_front and dfid_back

module delimited_frame_id_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] payload_byte, [18:8] frame_length, [26:19] msg_type,
	// [30:27] mapped_id, [32:31] frame_status, [39:33] zero
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast   // result_kind
);

	logic              space;
	logic              accept;
	logic              push;
	dfid_pkg::result_t result;

	// input transaction taken while the queue has room
	assign s_axis_tready = space;
	assign accept        = s_axis_tvalid && space;

	dfid_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_axis_tdata),
		.push    (push),
		.result  (result)
	);

	dfid_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_data     (result),
		.space         (space),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: verif/delimited_frame_id_decoder_tb.sv
// self-checking testbench for the delimited frame id decoder: byte stream in,
// payload and frame summary transactions out, checked against a local deframer
// depends on dfid_pkg and delimited_frame_id_decoder
`timescale 1ns / 100ps

module delimited_frame_id_decoder_tb;

	localparam int DRAIN_MARK = -1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 800;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_STALL = 300;
	localparam int STALL_AFTER = 200;
	// raw id codes, id 1 in the lowest byte up to id 13
	localparam logic [13*8-1:0] ID_CODES = {8'd238, 8'd106, 8'd107, 8'd108, 8'd103,
		8'd121, 8'd111, 8'd102, 8'd120, 8'd112, 8'd99, 8'd98, 8'd97};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] payload_byte, [18:8] frame_length, [26:19] msg_type,
	// [30:27] mapped_id, [32:31] frame_status, [39:33] zero
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;          // result_kind

	// byte stream still to send, with drain marks between phases
	int pending_bytes[$];
	// payload and summary transactions the decoder owes us, oldest first
	dfid_pkg::result_t expected_results[$];

	// local deframer state
	dfid_pkg::phase_t           dec_phase = dfid_pkg::PH_HUNT;
	logic                       held_ok = 1'b0;
	logic [7:0]                 held_byte = 8'h00;
	logic [dfid_pkg::LEN_W-1:0] payload_count = '0;
	logic [7:0]                 frame_type = 8'h00;
	logic [7:0]                 frame_raw_id = 8'h00;

	int  mismatch_count = 0;
	int  bytes_accepted = 0;
	int  results_checked = 0;
	int  n_ok = 0;
	int  n_short = 0;
	int  n_unknown = 0;
	int  n_overflow = 0;
	int  longest_frame = 0;
	int  cycle_count = 0;
	int  tx_gap = 0;
	int  rx_hold = 0;
	bit  offering = 1'b0;
	bit  long_stall_done = 1'b0;

	delimited_frame_id_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d transactions outstanding",
				$time, cycle_count, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// raw id byte to 1..13, 0 when not in the table
	function automatic logic [3:0] id_of(input logic [7:0] raw);
		logic [3:0] id;
		id = 4'd0;
		for (int i = 0; i < 13; i++)
			if (ID_CODES[i*8 +: 8] == raw)
				id = 4'(i + 1);
		return id;
	endfunction

	function automatic dfid_pkg::result_t frame_summary(input dfid_pkg::status_t status,
		input logic [3:0] id);
		dfid_pkg::result_t r;
		r = '0;
		r.kind = dfid_pkg::KIND_SUMMARY;
		r.frame_length = payload_count;
		r.msg_type = (payload_count >= 1) ? frame_type : 8'h00;
		r.mapped_id = id;
		r.frame_status = status;
		return r;
	endfunction

	// advance the local deframer by one received byte
	task automatic deframe_byte(input logic [7:0] b);
		dfid_pkg::result_t r;
		logic [3:0]        id;
		r = '0;
		case (dec_phase)
			dfid_pkg::PH_SEEN: begin
				if (b == dfid_pkg::BYTE_CR) begin
					dec_phase = dfid_pkg::PH_FRAME;
					held_ok = 1'b0;
					held_byte = 8'h00;
					payload_count = '0;
					frame_type = 8'h00;
					frame_raw_id = 8'h00;
				end else if (b == dfid_pkg::BYTE_LF) begin
					dec_phase = dfid_pkg::PH_SEEN;
				end else begin
					dec_phase = dfid_pkg::PH_HUNT;
				end
			end
			dfid_pkg::PH_FRAME: begin
				if (!held_ok) begin
					held_ok = 1'b1;
					held_byte = b;
				end else if (held_byte == dfid_pkg::BYTE_CR && b == dfid_pkg::BYTE_LF) begin
					// tail: close the frame
					if (payload_count < 2) begin
						expected_results.push_back(frame_summary(dfid_pkg::ST_SHORT, 4'd0));
					end else begin
						id = id_of(frame_raw_id);
						if (id != 4'd0)
							expected_results.push_back(frame_summary(dfid_pkg::ST_OK, id));
						else
							expected_results.push_back(
								frame_summary(dfid_pkg::ST_UNKNOWN_ID, 4'd0));
					end
					held_ok = 1'b0;
					held_byte = 8'h00;
					dec_phase = dfid_pkg::PH_HUNT;
				end else if (payload_count >= dfid_pkg::FRAME_LIMIT) begin
					// too long: abort, incoming byte restarts the hunt
					expected_results.push_back(frame_summary(dfid_pkg::ST_OVERFLOW, 4'd0));
					held_ok = 1'b0;
					held_byte = 8'h00;
					if (b == dfid_pkg::BYTE_LF)
						dec_phase = dfid_pkg::PH_SEEN;
					else
						dec_phase = dfid_pkg::PH_HUNT;
				end else begin
					// release the held byte, hold the new one
					r.kind = dfid_pkg::KIND_PAYLOAD;
					r.payload_byte = held_byte;
					expected_results.push_back(r);
					if (payload_count == 0)
						frame_type = held_byte;
					else if (payload_count == 1)
						frame_raw_id = held_byte;
					payload_count++;
					held_byte = b;
				end
			end
			default: begin
				if (b == dfid_pkg::BYTE_LF)
					dec_phase = dfid_pkg::PH_SEEN;
				else
					dec_phase = dfid_pkg::PH_HUNT;
			end
		endcase
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// idle lengths: mostly none or short, a few long, and quiet stretches with none
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (cycle_count[8:7] == 2'd0)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// monitor: check output transactions, then record accepted input bytes
	always @(posedge clk) begin : monitor
		dfid_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected transaction, expected none actual tdata %h tlast %b",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("result_kind", want.kind, m_axis_tlast);
				check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
				check_field("frame_length", want.frame_length, m_axis_tdata[18:8]);
				check_field("msg_type", want.msg_type, m_axis_tdata[26:19]);
				check_field("mapped_id", want.mapped_id, m_axis_tdata[30:27]);
				check_field("frame_status", want.frame_status, m_axis_tdata[32:31]);
				check_field("tdata padding", 0, m_axis_tdata[39:33]);
				if (want.kind == dfid_pkg::KIND_SUMMARY) begin
					case (want.frame_status)
						dfid_pkg::ST_OK:         n_ok++;
						dfid_pkg::ST_SHORT:      n_short++;
						dfid_pkg::ST_UNKNOWN_ID: n_unknown++;
						default:                 n_overflow++;
					endcase
					if (want.frame_length > longest_frame)
						longest_frame = want.frame_length;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			deframe_byte(s_axis_tdata);
			bytes_accepted++;
			offering = 1'b0;
		end
	end

	// driver: offer pending bytes with random gaps, hold at drain marks
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!offering) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes[0] == DRAIN_MARK) begin
				s_axis_tvalid <= 1'b0;
				if (expected_results.size() == 0)
					void'(pending_bytes.pop_front());
			end else begin
				s_axis_tdata <= 8'(pending_bytes.pop_front());
				s_axis_tvalid <= 1'b1;
				offering = 1'b1;
				tx_gap = pick_gap();
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else if (!long_stall_done && bytes_accepted >= STALL_AFTER) begin
			m_axis_tready <= 1'b0;
			rx_hold = LONG_STALL;
			long_stall_done = 1'b1;
		end else if (!m_axis_tready) begin
			m_axis_tready <= 1'b1;
			rx_hold = $urandom_range(0, 6);
		end else begin
			rx_hold = pick_gap();
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold--;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(int'(b));
	endtask

	// header, type byte, id byte, filler, tail; clean filler avoids cr and lf
	task automatic queue_frame(input int len, input bit known_id, input bit clean);
		logic [7:0] raw;
		push_byte(dfid_pkg::BYTE_LF);
		push_byte(dfid_pkg::BYTE_CR);
		for (int i = 0; i < len; i++) begin
			if (i == 1) begin
				if (known_id) begin
					raw = ID_CODES[$urandom_range(0, 12)*8 +: 8];
				end else begin
					raw = 8'($urandom_range(0, 255));
					while (id_of(raw) != 4'd0)
						raw = 8'($urandom_range(0, 255));
				end
				push_byte(raw);
			end else if (clean) begin
				push_byte(8'($urandom_range(14, 255)));
			end else begin
				push_byte(8'($urandom_range(0, 255)));
			end
		end
		push_byte(dfid_pkg::BYTE_CR);
		push_byte(dfid_pkg::BYTE_LF);
	endtask

	// stimulus and end of run
	initial begin : stimulus
		logic [7:0] opening [0:24];
		logic [7:0] b;
		int         r;
		int         random_end;
		int         next_drain;

		// repeated lf before cr, empty frame, one-byte frame, top id with
		// zero type, unknown id, broken header
		opening = '{8'h0A, 8'h0A, 8'h0D, 8'h0D, 8'h0A,
			8'h0A, 8'h0D, 8'hFF, 8'h0D, 8'h0A,
			8'h0A, 8'h0D, 8'h00, 8'hEE, 8'h55, 8'h0D, 8'h0A,
			8'h0A, 8'h0D, 8'h7F, 8'h80, 8'h0D, 8'h0A,
			8'h0A, 8'h41};
		for (int i = 0; i < 25; i++)
			push_byte(opening[i]);
		pending_bytes.push_back(DRAIN_MARK);

		// random traffic, mostly well-formed frames
		random_end = pending_bytes.size() + RANDOM_ITEMS;
		next_drain = pending_bytes.size() + 250;
		while (pending_bytes.size() < random_end) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				queue_frame($urandom_range(2, 12), 1'b1, 1'b0);
			end else if (r < 65) begin
				queue_frame($urandom_range(0, 1), 1'b1, 1'b0);
			end else if (r < 75) begin
				queue_frame($urandom_range(2, 8), 1'b0, 1'b0);
			end else if (r < 83) begin
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(0, 255)));
			end else if (r < 90) begin
				// header start followed by a wrong byte
				push_byte(dfid_pkg::BYTE_LF);
				b = 8'($urandom_range(0, 255));
				if (b == dfid_pkg::BYTE_CR)
					b = 8'h41;
				push_byte(b);
			end else begin
				// frame left without a tail
				push_byte(dfid_pkg::BYTE_LF);
				push_byte(dfid_pkg::BYTE_CR);
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom_range(0, 255)));
			end
			if (pending_bytes.size() >= next_drain) begin
				pending_bytes.push_back(DRAIN_MARK);
				next_drain = pending_bytes.size() + 250;
			end
		end
		pending_bytes.push_back(DRAIN_MARK);

		// frame of exactly the length limit
		queue_frame(dfid_pkg::LIMIT_INT, 1'b1, 1'b1);
		pending_bytes.push_back(DRAIN_MARK);
		// overflow where the aborting byte is lf and starts the next header
		push_byte(dfid_pkg::BYTE_LF);
		push_byte(dfid_pkg::BYTE_CR);
		repeat (dfid_pkg::LIMIT_INT + 1)
			push_byte(8'($urandom_range(14, 255)));
		queue_frame(3, 1'b1, 1'b0);
		// overflow on an ordinary byte, the tail then lands in the hunt
		push_byte(dfid_pkg::BYTE_LF);
		push_byte(dfid_pkg::BYTE_CR);
		repeat (dfid_pkg::LIMIT_INT + 2)
			push_byte(8'($urandom_range(14, 255)));
		push_byte(dfid_pkg::BYTE_CR);
		push_byte(dfid_pkg::BYTE_LF);
		queue_frame(4, 1'b1, 1'b0);

		// reset
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the stream to finish and every transaction to arrive
		while (pending_bytes.size() != 0 || offering || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d bytes sent, %0d output transactions checked, %0d mismatches",
			bytes_accepted, results_checked, mismatch_count);
		$display("frames: %0d ok, %0d short, %0d unknown id, %0d overflow, longest %0d",
			n_ok, n_short, n_unknown, n_overflow, longest_frame);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
